FILE: rtl/core/encoder_distance_motor_ramp_macros.svh
`ifndef ENCODER_DISTANCE_MOTOR_RAMP_MACROS_SVH
`define ENCODER_DISTANCE_MOTOR_RAMP_MACROS_SVH

// Clocked check, disabled while reset is active.
`define EDMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never occur.
`define EDMR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/core/edmr_pkg.sv
`timescale 1ns / 1ps
package edmr_pkg;

  // Ramp behavior constants
  localparam int unsigned RampDownDelta  = 16;
  localparam int unsigned RampDownOffset = 50;
  localparam int unsigned MinSpeed       = 30;
  localparam int unsigned SpeedScale     = 1100;
  localparam int unsigned DecelTimes2    = 4000;
  localparam int unsigned SpeedTimeoutMs = 1000;
  localparam int unsigned DecelDivider   = 100;
  localparam int unsigned DecelDiv       = DecelTimes2 / DecelDivider;

  // Divider sizing: speed fits SPD_W bits, its square fits DIV_NUM_W bits
  localparam int unsigned SPD_W     = $clog2(SpeedScale + 1);
  localparam int unsigned DIV_NUM_W = 2 * SPD_W;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned BRK_W     = DIV_NUM_W;

  // Braking distance: speed^2 / DecelDiv as multiply by a rounded-up reciprocal.
  // Exact while square * (BrkRecip * DecelDiv - 2^BrkShift) < 2^BrkShift.
  localparam int unsigned BrkShift = 26;
  localparam int unsigned BrkRecip = ((1 << BrkShift) + DecelDiv - 1) / DecelDiv;

  // Request kinds
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_GO   = 2'd2;
  localparam logic [1:0] REQ_STOP = 2'd3;

  // Ramp phases
  localparam logic [2:0] PH_STOPPED   = 3'd0;
  localparam logic [2:0] PH_START     = 3'd1;
  localparam logic [2:0] PH_RAMP_UP   = 3'd2;
  localparam logic [2:0] PH_DRIVE     = 3'd3;
  localparam logic [2:0] PH_RAMP_DOWN = 3'd4;
  localparam logic [2:0] PH_CHECK     = 3'd5;

  // Bridge modes
  localparam logic [1:0] MODE_FWD     = 2'd0;
  localparam logic [1:0] MODE_BWD     = 2'd1;
  localparam logic [1:0] MODE_BRAKE   = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  // Stop request modes
  localparam logic [1:0] STOP_KEEP    = 2'd0;
  localparam logic [1:0] STOP_BRAKE   = 2'd1;
  localparam logic [1:0] STOP_RELEASE = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_SPEED_COMP = 3'd0;
  localparam logic [2:0] REG_STOP_MODE  = 3'd1;
  localparam logic [2:0] REG_RING       = 3'd2;
  localparam logic [2:0] REG_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_RAMP_INT   = 3'd4;
  localparam logic [2:0] REG_UP_OFFSET  = 3'd5;
  localparam logic [2:0] REG_UP_DELTA   = 3'd6;
  localparam logic [2:0] REG_MM_PER_CNT = 3'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic incr_now;
    logic div_start;
    logic spd_cap;
    logic sq_cap;
    logic brk_cap;
    logic update;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_tick;
    logic div_done;
    logic out_free;
  } sts_t;

  // Wrapping time compare: t is now or in the past
  function automatic logic time_reached(input logic [31:0] now, input logic [31:0] t);
    logic [31:0] d;
    d = now - t;
    return !d[31];
  endfunction

endpackage

FILE: rtl/core/edmr_in_if.sv
`timescale 1ns / 1ps
interface edmr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  speed_pwm;
  logic [15:0] distance_mm;
  logic        move_direction;
  logic [1:0]  stop_mode;

  modport source (output valid, req_type, speed_pwm, distance_mm, move_direction,
                  stop_mode, input ready);
  modport sink (input valid, req_type, speed_pwm, distance_mm, move_direction,
                stop_mode, output ready);
endinterface

FILE: rtl/core/edmr_out_if.sv
`timescale 1ns / 1ps
interface edmr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pwm_main;
  logic [7:0]  pwm_compensated;
  logic [1:0]  drive_mode;
  logic [2:0]  ramp_phase;
  logic        moving;
  logic [15:0] count_now;

  modport source (output valid, pwm_main, pwm_compensated, drive_mode, ramp_phase,
                  moving, count_now, input ready);
  modport sink (input valid, pwm_main, pwm_compensated, drive_mode, ramp_phase,
                moving, count_now, output ready);
endinterface

FILE: rtl/core/edmr_div.sv
`timescale 1ns / 1ps
module edmr_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [edmr_pkg::DIV_NUM_W-1:0]      num_i,
  input  logic [edmr_pkg::DIV_DEN_W-1:0]      den_i,
  output logic                                done_o,
  output logic [edmr_pkg::DIV_NUM_W-1:0]      quo_o
);
  localparam int unsigned NW = edmr_pkg::DIV_NUM_W;
  localparam int unsigned DW = edmr_pkg::DIV_DEN_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, rem_d, den_q;
  logic [NW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   shifted;
  logic          fits;

  // One restoring step per cycle
  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    fits    = shifted >= {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: rtl/core/edmr_ctrl.sv
`timescale 1ns / 1ps
`include "encoder_distance_motor_ramp_macros.svh"
module edmr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  edmr_pkg::sts_t sts_i,
  output edmr_pkg::cmd_t cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_D1   = 3'd2;
  localparam logic [2:0] S_D1W  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_BRK  = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;

  logic [2:0] state_q, state_d;

  // Sequencer: ticks run the braking-distance computation, others go straight to update
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = sts_i.in_tick ? S_PREP : S_UPD;
        end
      end
      S_PREP: begin
        cmd_o.incr_now = 1'b1;
        state_d        = S_D1;
      end
      S_D1: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_D1W;
      end
      S_D1W: begin
        if (sts_i.div_done) begin
          cmd_o.spd_cap = 1'b1;
          state_d       = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_cap = 1'b1;
        state_d      = S_BRK;
      end
      // Reciprocal multiply for braking distance
      S_BRK: begin
        cmd_o.brk_cap = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  `EDMR_ASSERT(a_accept_leaves_idle, (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE), "accepted beat did not start work")
  `EDMR_NEVER(a_done_when_waiting, sts_i.div_done && state_q != S_D1W, "divider result outside wait state")
  `EDMR_ASSERT(a_update_returns, cmd_o.update |=> (state_q == S_IDLE), "update not followed by idle")
endmodule

FILE: rtl/core/edmr_dp.sv
`timescale 1ns / 1ps
module edmr_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  edmr_pkg::cmd_t cmd_i,
  output edmr_pkg::sts_t sts_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  input  logic [1:0]     req_type_i,
  input  logic [7:0]     speed_pwm_i,
  input  logic [15:0]    distance_mm_i,
  input  logic           move_direction_i,
  input  logic [1:0]     stop_mode_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [7:0]     pwm_main_o,
  output logic [7:0]     pwm_compensated_o,
  output logic [1:0]     drive_mode_o,
  output logic [2:0]     ramp_phase_o,
  output logic           moving_o,
  output logic [15:0]    count_now_o
);
  localparam int unsigned NW = edmr_pkg::DIV_NUM_W;
  localparam int unsigned SW = edmr_pkg::SPD_W;
  localparam int unsigned BW = edmr_pkg::BRK_W;
  localparam int unsigned RW = $clog2(edmr_pkg::BrkRecip + 1);

  // Configuration
  logic [7:0]  spd_comp_q, ring_q, ramp_int_q, up_off_q, up_delta_q, mm_cnt_q;
  logic        def_stop_q;
  logic [15:0] timeout_q;

  // Motion state
  logic [31:0] now_q, last_q, nxt_q;
  logic [15:0] gap_q, cnt_q, tgt_q;
  logic [7:0]  req_q, comp_q, dtp_q;
  logic [2:0]  ph_q;
  logic        chk_q;
  logic [1:0]  bridge_q;

  // Latched beat and arithmetic results
  logic [1:0]  kind_q, sm_q;
  logic [7:0]  p_q;
  logic [15:0] dist_q;
  logic        dir_q;
  logic [SW-1:0] spd_q;
  logic [NW-1:0] sq_q;
  logic [BW-1:0] brake_q;

  // Output register
  logic        ov_q;
  logic [7:0]  o_pwm_q, o_comp_q;
  logic [1:0]  o_mode_q;
  logic [2:0]  o_ph_q;
  logic [15:0] o_cnt_q;

  // Divider for speed = scale / gap; brake = speed^2 / decel by reciprocal multiply
  logic [31:0]      edge_age;
  logic             spd_to;
  logic [15:0]      gap_eff;
  logic [NW-1:0]    div_num, div_quo;
  logic [15:0]      div_den;
  logic             div_done;
  logic [NW+RW-1:0] brk_prod;
  logic [23:0]      trav;
  logic             brk;

  assign edge_age = now_q - last_q;
  assign spd_to   = edge_age > 32'(edmr_pkg::SpeedTimeoutMs);
  assign gap_eff  = spd_to ? 16'd0 : gap_q;
  assign div_num  = NW'(edmr_pkg::SpeedScale);
  assign div_den  = gap_eff;
  assign brk_prod = sq_q * RW'(edmr_pkg::BrkRecip);
  assign trav     = cnt_q * mm_cnt_q;
  assign brk      = ({1'b0, trav} + 25'(brake_q)) >= 25'(tgt_q);

  edmr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign sts_o.in_tick  = req_type_i == edmr_pkg::REQ_TICK;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ov_q || out_ready_i;

  // Next motion state for the latched beat
  logic [31:0] u_last, u_nxt, d32;
  logic [15:0] u_gap, u_cnt, u_tgt;
  logic [7:0]  u_req, u_comp, u_dtp, np;
  logic [2:0]  u_ph;
  logic        u_chk, early, called, dir_match;
  logic [1:0]  u_bridge, hmode, dir2;
  logic [8:0]  sum9;

  always_comb begin
    u_last = last_q; u_nxt = nxt_q; u_gap = gap_q; u_cnt = cnt_q; u_tgt = tgt_q;
    u_req = req_q; u_comp = comp_q; u_dtp = dtp_q; u_ph = ph_q; u_chk = chk_q;
    u_bridge = bridge_q;
    np = req_q; early = 1'b0; called = 1'b0; hmode = edmr_pkg::STOP_KEEP;
    d32 = now_q - last_q; sum9 = '0;
    dir2 = {1'b0, dir_q};
    dir_match = bridge_q == dir2;
    unique case (kind_q)
      edmr_pkg::REQ_TICK: begin
        early = (req_q != 8'd0) && chk_q &&
                ({8'd0, trav} >= {16'd0, tgt_q} || d32 > {16'd0, timeout_q});
        if (early) begin
          u_req = '0; u_comp = '0; u_chk = 1'b0; u_ph = edmr_pkg::PH_STOPPED;
          u_bridge = edmr_pkg::MODE_BRAKE;
        end else begin
          called = chk_q && ((ph_q == edmr_pkg::PH_START && dtp_q <= up_off_q) ||
                             ph_q == edmr_pkg::PH_DRIVE ||
                             (ph_q == edmr_pkg::PH_RAMP_UP &&
                              edmr_pkg::time_reached(now_q, nxt_q)));
          if (called && spd_to) u_gap = '0;
          // Start and ramp up
          if (u_ph == edmr_pkg::PH_START) begin
            u_nxt = now_q + {24'd0, ramp_int_q};
            if (dtp_q > up_off_q) begin
              np = up_off_q; u_ph = edmr_pkg::PH_RAMP_UP;
            end else begin
              np = dtp_q; u_ph = edmr_pkg::PH_DRIVE;
            end
          end else if (u_ph == edmr_pkg::PH_RAMP_UP) begin
            if (edmr_pkg::time_reached(now_q, u_nxt)) begin
              u_nxt = u_nxt + {24'd0, ramp_int_q};
              if (np == dtp_q || (chk_q && brk)) begin
                u_ph = edmr_pkg::PH_DRIVE;
              end else begin
                np = np + up_delta_q;
                if (np > dtp_q || np <= up_delta_q) np = dtp_q;
              end
            end
          end
          // Braking point
          if (u_ph == edmr_pkg::PH_DRIVE && chk_q && brk) begin
            if (req_q > 8'(edmr_pkg::RampDownOffset)) begin
              sum9 = {1'b0, np} - 9'(edmr_pkg::RampDownOffset - edmr_pkg::RampDownDelta);
              np   = sum9[8] ? 8'd0 : sum9[7:0];
            end else begin
              np = 8'(edmr_pkg::MinSpeed);
            end
            u_ph = edmr_pkg::PH_RAMP_DOWN;
          end
          // Ramp down
          if (u_ph == edmr_pkg::PH_RAMP_DOWN && edmr_pkg::time_reached(now_q, u_nxt)) begin
            u_nxt = now_q + {24'd0, ramp_int_q};
            if (np == 8'(edmr_pkg::MinSpeed)) begin
              if (!chk_q) np = 8'd0;
              else        u_ph = edmr_pkg::PH_CHECK;
            end else if (np < 8'(edmr_pkg::RampDownDelta + edmr_pkg::MinSpeed)) begin
              np = 8'(edmr_pkg::MinSpeed);
            end else begin
              np = np - 8'(edmr_pkg::RampDownDelta);
            end
          end
          // Apply the new PWM
          if (np != req_q) begin
            u_req = np;
            if (np == 8'd0) begin
              u_comp = '0; u_chk = 1'b0; u_ph = edmr_pkg::PH_STOPPED;
              u_bridge = def_stop_q ? edmr_pkg::MODE_RELEASE : edmr_pkg::MODE_BRAKE;
            end else begin
              u_comp = (np > spd_comp_q) ? np - spd_comp_q : 8'd0;
            end
          end
        end
      end
      edmr_pkg::REQ_EDGE: begin
        if (d32 > {24'd0, ring_q}) begin
          u_last = now_q;
          u_gap  = (d32 < {16'd0, timeout_q}) ? d32[15:0] : 16'd0;
          u_cnt  = cnt_q + 16'd1;
        end
      end
      edmr_pkg::REQ_GO: begin
        if (dist_q == 16'd0) begin
          u_req = '0; u_comp = '0; u_chk = 1'b0; u_ph = edmr_pkg::PH_STOPPED;
          u_bridge = def_stop_q ? edmr_pkg::MODE_RELEASE : edmr_pkg::MODE_BRAKE;
        end else begin
          u_cnt  = '0;
          u_last = now_q - {24'd0, ring_q} - 32'd1;
          u_tgt  = dist_q;
          if (req_q == 8'd0 && p_q > up_off_q &&
              !(ph_q == edmr_pkg::PH_DRIVE && dir_match)) begin
            // Ramped start; direction change needs no halt as PWM is zero
            u_bridge = dir2;
            u_ph     = edmr_pkg::PH_START;
            u_dtp    = p_q;
          end else if (p_q == 8'd0) begin
            u_req = '0; u_comp = '0; u_ph = edmr_pkg::PH_STOPPED;
            u_bridge = def_stop_q ? edmr_pkg::MODE_RELEASE : edmr_pkg::MODE_BRAKE;
          end else begin
            if (!dir_match && req_q != 8'd0) u_ph = edmr_pkg::PH_STOPPED;
            u_bridge = dir2;
            u_req    = p_q;
            u_comp   = (p_q > spd_comp_q) ? p_q - spd_comp_q : 8'd0;
          end
          u_chk = 1'b1;
        end
      end
      edmr_pkg::REQ_STOP: begin
        u_req = '0; u_comp = '0; u_chk = 1'b0; u_ph = edmr_pkg::PH_STOPPED;
        hmode = sm_q;
        if (hmode == edmr_pkg::STOP_BRAKE)        u_bridge = edmr_pkg::MODE_BRAKE;
        else if (hmode == edmr_pkg::STOP_RELEASE) u_bridge = edmr_pkg::MODE_RELEASE;
        else u_bridge = def_stop_q ? edmr_pkg::MODE_RELEASE : edmr_pkg::MODE_BRAKE;
      end
      default: u_ph = ph_q;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_comp_q <= 8'd2;  def_stop_q <= 1'b0;  ring_q    <= 8'd2;
      timeout_q  <= 16'd200; ramp_int_q <= 8'd20; up_off_q <= 8'd50;
      up_delta_q <= 8'd8;  mm_cnt_q   <= 8'd11;
      now_q <= '0; last_q <= '0; nxt_q <= '0; gap_q <= '0; cnt_q <= '0; tgt_q <= '0;
      req_q <= '0; comp_q <= '0; dtp_q <= '0; ph_q <= edmr_pkg::PH_STOPPED;
      chk_q <= 1'b0; bridge_q <= edmr_pkg::MODE_BRAKE; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          edmr_pkg::REG_SPEED_COMP: spd_comp_q <= cfg_data_i[7:0];
          edmr_pkg::REG_STOP_MODE:  def_stop_q <= cfg_data_i[0];
          edmr_pkg::REG_RING:       ring_q     <= cfg_data_i[7:0];
          edmr_pkg::REG_TIMEOUT:    timeout_q  <= cfg_data_i;
          edmr_pkg::REG_RAMP_INT:   ramp_int_q <= cfg_data_i[7:0];
          edmr_pkg::REG_UP_OFFSET:  up_off_q   <= cfg_data_i[7:0];
          edmr_pkg::REG_UP_DELTA:   up_delta_q <= cfg_data_i[7:0];
          edmr_pkg::REG_MM_PER_CNT: mm_cnt_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.incr_now) now_q <= now_q + 32'd1;
      if (cmd_i.update) begin
        last_q <= u_last; nxt_q <= u_nxt; gap_q <= u_gap; cnt_q <= u_cnt; tgt_q <= u_tgt;
        req_q <= u_req; comp_q <= u_comp; dtp_q <= u_dtp; ph_q <= u_ph; chk_q <= u_chk;
        bridge_q <= u_bridge;
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= req_type_i; p_q <= speed_pwm_i; dist_q <= distance_mm_i;
      dir_q  <= move_direction_i; sm_q <= stop_mode_i;
    end
    if (cmd_i.spd_cap) spd_q <= (gap_eff == 16'd0) ? '0 : div_quo[SW-1:0];
    if (cmd_i.sq_cap)  sq_q  <= spd_q * spd_q;
    if (cmd_i.brk_cap) brake_q <= BW'(brk_prod >> edmr_pkg::BrkShift);
    if (cmd_i.update) begin
      o_pwm_q <= u_req; o_comp_q <= u_comp; o_mode_q <= u_bridge;
      o_ph_q  <= u_ph;  o_cnt_q  <= u_cnt;
    end
  end

  assign out_valid_o       = ov_q;
  assign pwm_main_o        = o_pwm_q;
  assign pwm_compensated_o = o_comp_q;
  assign drive_mode_o      = o_mode_q;
  assign ramp_phase_o      = o_ph_q;
  assign moving_o          = o_pwm_q != 8'd0;
  assign count_now_o       = o_cnt_q;
endmodule

FILE: rtl/core/encoder_distance_motor_ramp.sv
`timescale 1ns / 1ps
// Tick beats: the result is set by one pass of the 22-step divider (speed), a square
// and a reciprocal multiply before the update.
// Edge, go and stop beats skip the arithmetic and go straight to the update.
// One beat is in work at a time; the next is accepted while the previous result
// waits in the output register, and a stalled output holds off the update.
// Reset (async, active low) restores register defaults and a stopped, braked motor.
module encoder_distance_motor_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  edmr_in_if.sink     in_ch,
  edmr_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  edmr_pkg::cmd_t cmd;
  edmr_pkg::sts_t sts;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  edmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  edmr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .req_type_i        (in_ch.req_type),
    .speed_pwm_i       (in_ch.speed_pwm),
    .distance_mm_i     (in_ch.distance_mm),
    .move_direction_i  (in_ch.move_direction),
    .stop_mode_i       (in_ch.stop_mode),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .pwm_main_o        (out_ch.pwm_main),
    .pwm_compensated_o (out_ch.pwm_compensated),
    .drive_mode_o      (out_ch.drive_mode),
    .ramp_phase_o      (out_ch.ramp_phase),
    .moving_o          (out_ch.moving),
    .count_now_o       (out_ch.count_now)
  );
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  edmr_in_if  in_ch ();
  edmr_out_if out_ch ();

  encoder_distance_motor_ramp DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  typedef struct packed {
    logic [7:0]  pwm_main;
    logic [7:0]  pwm_comp;
    logic [1:0]  drive_mode;
    logic [2:0]  phase;
    logic        moving;
    logic [15:0] count;
  } motor_status_t;

  // Predicted register copy
  logic [7:0]  r_comp, r_ring, r_ramp_int, r_up_off, r_up_delta, r_mm;
  logic        r_dflt_stop;
  logic [15:0] r_timeout;

  // Predicted motor state
  logic [31:0] now_ms, last_edge_ms, next_step_ms;
  logic [15:0] edge_gap, edge_cnt, target_mm;
  logic [7:0]  req_pwm, comp_pwm, drive_pwm;
  logic [2:0]  ramp_ph;
  logic        check_stop;
  logic [1:0]  bridge;

  motor_status_t status_q[$];
  int unsigned   n_items, n_results, n_errors, n_cfg;
  int unsigned   send_idle_pct, recv_stall_pct;

  // Clock, timeout
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------- motor predictor ----------------
  function automatic bit time_passed(input logic [31:0] t);
    logic [31:0] d;
    d = now_ms - t;
    return !d[31];
  endfunction

  function automatic void motor_halt(input bit keep, input logic [1:0] mode);
    req_pwm    = '0;
    comp_pwm   = '0;
    check_stop = 1'b0;
    ramp_ph    = edmr_pkg::PH_STOPPED;
    if (keep) bridge = r_dflt_stop ? edmr_pkg::MODE_RELEASE : edmr_pkg::MODE_BRAKE;
    else bridge = mode;
  endfunction

  function automatic void motor_set_pwm(input logic [7:0] p);
    req_pwm = p;
    if (p == 0) motor_halt(1'b1, edmr_pkg::MODE_BRAKE);
    else comp_pwm = (p > r_comp) ? p - r_comp : 8'd0;
  endfunction

  function automatic void motor_set_dir(input logic [1:0] dir);
    if (bridge != dir) begin
      if (req_pwm != 0) motor_halt(1'b0, edmr_pkg::MODE_BRAKE);
      bridge = dir;
    end
  endfunction

  function automatic void motor_direct(input logic [7:0] p, input logic [1:0] dir);
    if (p == 0) begin
      motor_halt(1'b1, edmr_pkg::MODE_BRAKE);
    end else begin
      motor_set_dir(dir);
      motor_set_pwm(p);
    end
  endfunction

  function automatic void motor_ramped(input logic [7:0] p, input logic [1:0] dir);
    if (p <= r_up_off) begin
      motor_direct(p, dir);
    end else if (ramp_ph == edmr_pkg::PH_DRIVE && bridge == dir) begin
      motor_direct(p, dir);
    end else begin
      motor_set_dir(dir);
      ramp_ph   = edmr_pkg::PH_START;
      drive_pwm = p;
    end
  endfunction

  function automatic longint unsigned travelled();
    return longint'(edge_cnt) * longint'(r_mm);
  endfunction

  // Distance so far plus speed squared over deceleration reaches the target
  function automatic bit braking_due();
    longint unsigned spd, brk;
    spd = 0;
    if (now_ms - last_edge_ms > edmr_pkg::SpeedTimeoutMs) edge_gap = '0;
    if (edge_gap != 0) spd = edmr_pkg::SpeedScale / edge_gap;
    brk = (spd * spd) / edmr_pkg::DecelDiv;
    return travelled() + brk >= target_mm;
  endfunction

  function automatic void ramp_step();
    int unsigned np;
    int          v;
    np = req_pwm;
    if (np > 0 && check_stop &&
        (travelled() >= target_mm || now_ms - last_edge_ms > r_timeout)) begin
      motor_halt(1'b0, edmr_pkg::MODE_BRAKE);
      return;
    end
    if (ramp_ph == edmr_pkg::PH_START) begin
      next_step_ms = now_ms + r_ramp_int;
      if (drive_pwm > r_up_off) begin
        np      = r_up_off;
        ramp_ph = edmr_pkg::PH_RAMP_UP;
      end else begin
        np      = drive_pwm;
        ramp_ph = edmr_pkg::PH_DRIVE;
      end
    end else if (ramp_ph == edmr_pkg::PH_RAMP_UP) begin
      if (time_passed(next_step_ms)) begin
        next_step_ms = next_step_ms + r_ramp_int;
        if (np == drive_pwm || (check_stop && braking_due())) begin
          ramp_ph = edmr_pkg::PH_DRIVE;
        end else begin
          np = (np + r_up_delta) & 8'hFF;
          if (np > drive_pwm || np <= r_up_delta) np = drive_pwm;
        end
      end
    end
    if (ramp_ph == edmr_pkg::PH_DRIVE && check_stop && braking_due()) begin
      if (req_pwm > edmr_pkg::RampDownOffset) begin
        v = int'(np) - (int'(edmr_pkg::RampDownOffset) - int'(edmr_pkg::RampDownDelta));
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        np = v;
      end else begin
        np = edmr_pkg::MinSpeed;
      end
      ramp_ph = edmr_pkg::PH_RAMP_DOWN;
    end
    if (ramp_ph == edmr_pkg::PH_RAMP_DOWN && time_passed(next_step_ms)) begin
      next_step_ms = now_ms + r_ramp_int;
      if (np == edmr_pkg::MinSpeed) begin
        if (!check_stop) np = 0;
        else ramp_ph = edmr_pkg::PH_CHECK;
      end else if (np < edmr_pkg::RampDownDelta + edmr_pkg::MinSpeed) begin
        np = edmr_pkg::MinSpeed;
      end else begin
        np = np - edmr_pkg::RampDownDelta;
      end
    end
    if (np != req_pwm) motor_set_pwm(np[7:0]);
  endfunction

  function automatic void encoder_beat();
    logic [31:0] d;
    d = now_ms - last_edge_ms;
    if (d <= r_ring) return;
    last_edge_ms = now_ms;
    edge_gap     = (d < r_timeout) ? d[15:0] : 16'd0;
    edge_cnt     = edge_cnt + 16'd1;
  endfunction

  function automatic motor_status_t motor_predict(input logic [1:0] kind,
      input logic [7:0] spd, input logic [15:0] dist_mm, input logic dir,
      input logic [1:0] sm);
    motor_status_t s;
    case (kind)
      edmr_pkg::REQ_TICK: begin
        now_ms = now_ms + 32'd1;
        ramp_step();
      end
      edmr_pkg::REQ_EDGE: encoder_beat();
      edmr_pkg::REQ_GO: begin
        if (dist_mm == 0) begin
          motor_halt(1'b1, edmr_pkg::MODE_BRAKE);
        end else begin
          edge_cnt     = '0;
          last_edge_ms = now_ms - r_ring - 32'd1;
          target_mm    = dist_mm;
          if (req_pwm == 0) motor_ramped(spd, {1'b0, dir});
          else motor_direct(spd, {1'b0, dir});
          check_stop = 1'b1;
        end
      end
      default: begin
        if (sm == edmr_pkg::STOP_BRAKE) motor_halt(1'b0, edmr_pkg::MODE_BRAKE);
        else if (sm == edmr_pkg::STOP_RELEASE) motor_halt(1'b0, edmr_pkg::MODE_RELEASE);
        else motor_halt(1'b1, edmr_pkg::MODE_BRAKE);
      end
    endcase
    s.pwm_main   = req_pwm;
    s.pwm_comp   = comp_pwm;
    s.drive_mode = bridge;
    s.phase      = ramp_ph;
    s.moving     = (req_pwm != 0);
    s.count      = edge_cnt;
    return s;
  endfunction

  // ---------------- drivers ----------------
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_beat(input logic [1:0] kind, input logic [7:0] spd,
      input logic [15:0] dist_mm, input logic dir, input logic [1:0] sm);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          = 1'b1;
    in_ch.req_type       = kind;
    in_ch.speed_pwm      = spd;
    in_ch.distance_mm    = dist_mm;
    in_ch.move_direction = dir;
    in_ch.stop_mode      = sm;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    status_q.push_back(motor_predict(kind, spd, dist_mm, dir, sm));
    n_items++;
  endtask

  task automatic tick_beat();
    send_beat(edmr_pkg::REQ_TICK, 8'($urandom), 16'($urandom), 1'($urandom),
              2'($urandom));
  endtask

  task automatic edge_beat();
    send_beat(edmr_pkg::REQ_EDGE, 8'($urandom), 16'($urandom), 1'($urandom),
              2'($urandom));
  endtask

  // Wait until every predicted status has come back
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      edmr_pkg::REG_SPEED_COMP: r_comp      = val[7:0];
      edmr_pkg::REG_STOP_MODE:  r_dflt_stop = val[0];
      edmr_pkg::REG_RING:       r_ring      = val[7:0];
      edmr_pkg::REG_TIMEOUT:    r_timeout   = val;
      edmr_pkg::REG_RAMP_INT:   r_ramp_int  = val[7:0];
      edmr_pkg::REG_UP_OFFSET:  r_up_off    = val[7:0];
      edmr_pkg::REG_UP_DELTA:   r_up_delta  = val[7:0];
      default:                  r_mm        = val[7:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_setting(input logic [7:0] comp, input logic dstop,
      input logic [7:0] ring, input logic [15:0] tmo, input logic [7:0] rint,
      input logic [7:0] uoff, input logic [7:0] udelta, input logic [7:0] mm);
    drain();
    repeat (60) @(posedge clk_i);
    write_reg(edmr_pkg::REG_SPEED_COMP, {8'd0, comp});
    write_reg(edmr_pkg::REG_STOP_MODE, {15'd0, dstop});
    write_reg(edmr_pkg::REG_RING, {8'd0, ring});
    write_reg(edmr_pkg::REG_TIMEOUT, tmo);
    write_reg(edmr_pkg::REG_RAMP_INT, {8'd0, rint});
    write_reg(edmr_pkg::REG_UP_OFFSET, {8'd0, uoff});
    write_reg(edmr_pkg::REG_UP_DELTA, {8'd0, udelta});
    write_reg(edmr_pkg::REG_MM_PER_CNT, {8'd0, mm});
    n_cfg++;
  endtask

  // ---------------- result check ----------------
  always @(posedge clk_i) begin
    motor_status_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (status_q.size() == 0) begin
        $error("status beat with nothing predicted");
        n_errors++;
      end else begin
        e = status_q.pop_front();
        if (out_ch.pwm_main !== e.pwm_main) begin
          $error("pwm_main exp %0d got %0d", e.pwm_main, out_ch.pwm_main);
          n_errors++;
        end
        if (out_ch.pwm_compensated !== e.pwm_comp) begin
          $error("pwm_compensated exp %0d got %0d", e.pwm_comp, out_ch.pwm_compensated);
          n_errors++;
        end
        if (out_ch.drive_mode !== e.drive_mode) begin
          $error("drive_mode exp %0d got %0d", e.drive_mode, out_ch.drive_mode);
          n_errors++;
        end
        if (out_ch.ramp_phase !== e.phase) begin
          $error("ramp_phase exp %0d got %0d", e.phase, out_ch.ramp_phase);
          n_errors++;
        end
        if (out_ch.moving !== e.moving) begin
          $error("moving exp %0d got %0d", e.moving, out_ch.moving);
          n_errors++;
        end
        if (out_ch.count_now !== e.count) begin
          $error("count_now exp %0d got %0d", e.count, out_ch.count_now);
          n_errors++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    // every stop mode, including the undefined one treated as keep
    send_beat(edmr_pkg::REQ_STOP, 8'd0, 16'd0, 1'b0, edmr_pkg::STOP_KEEP);
    send_beat(edmr_pkg::REQ_STOP, 8'd0, 16'd0, 1'b0, edmr_pkg::STOP_BRAKE);
    send_beat(edmr_pkg::REQ_STOP, 8'd0, 16'd0, 1'b0, edmr_pkg::STOP_RELEASE);
    send_beat(edmr_pkg::REQ_STOP, 8'hFF, 16'hFFFF, 1'b1, 2'd3);
    // zero distance is a stop; zero speed stops but keeps checking
    send_beat(edmr_pkg::REQ_GO, 8'd200, 16'd0, 1'b0, edmr_pkg::STOP_KEEP);
    send_beat(edmr_pkg::REQ_GO, 8'd0, 16'd100, 1'b1, edmr_pkg::STOP_KEEP);
    tick_beat();
    // full speed backward, long target, ramp up with edges
    send_beat(edmr_pkg::REQ_GO, 8'hFF, 16'hFFFF, 1'b1, edmr_pkg::STOP_KEEP);
    repeat (3) tick_beat();
    edge_beat();
    edge_beat();  // ringing, ignored
    repeat (4) tick_beat();
    edge_beat();
    // go while moving: direct drive, direction change sets the phase to stopped
    send_beat(edmr_pkg::REQ_GO, 8'd40, 16'd22, 1'b0, edmr_pkg::STOP_KEEP);
    repeat (3) tick_beat();
    edge_beat();
    tick_beat();
    edge_beat();
    tick_beat();
    send_beat(edmr_pkg::REQ_STOP, 8'd0, 16'd0, 1'b0, edmr_pkg::STOP_RELEASE);
  endtask

  // Motions with random content; a minority of noise items
  task automatic test_motion(input int unsigned n_target, input int unsigned idle,
      input int unsigned stall);
    int unsigned start, len, edge_pct;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = n_items;
    while (n_items - start < n_target) begin
      if ($urandom_range(99) < 85) begin
        send_beat(edmr_pkg::REQ_GO,
                  ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40, 255)),
                  ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 500)),
                  1'($urandom), 2'($urandom));
        len      = $urandom_range(10, 120);
        if (len > n_target - (n_items - start)) len = n_target - (n_items - start);
        edge_pct = $urandom_range(0, 60);
        repeat (len) begin
          if ($urandom_range(99) < edge_pct) edge_beat();
          else if ($urandom_range(199) == 0)
            send_beat(edmr_pkg::REQ_STOP, 8'($urandom), 16'($urandom), 1'($urandom),
                      2'($urandom));
          else if ($urandom_range(149) == 0)
            send_beat(edmr_pkg::REQ_GO, 8'($urandom), 16'($urandom), 1'($urandom),
                      2'($urandom));
          else tick_beat();
        end
      end else begin
        repeat ($urandom_range(1, 8))
          send_beat(2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                    2'($urandom));
      end
    end
  endtask

  // Long coast with sparse edges so the speed timeout clears the gap
  task automatic test_speed_timeout();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(edmr_pkg::REQ_GO, 8'd255, 16'd4000, 1'b0, edmr_pkg::STOP_KEEP);
    repeat (6) tick_beat();
    edge_beat();
    repeat (1010) tick_beat();
    edge_beat();
    tick_beat();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = edmr_pkg::REG_SPEED_COMP;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = edmr_pkg::REQ_TICK;
    in_ch.speed_pwm      = '0;
    in_ch.distance_mm    = '0;
    in_ch.move_direction = 1'b0;
    in_ch.stop_mode      = edmr_pkg::STOP_KEEP;
    out_ch.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    n_items = 0; n_results = 0; n_errors = 0; n_cfg = 0;
    r_comp = 8'd2; r_dflt_stop = 1'b0; r_ring = 8'd2; r_timeout = 16'd200;
    r_ramp_int = 8'd20; r_up_off = 8'd50; r_up_delta = 8'd8; r_mm = 8'd11;
    now_ms = '0; last_edge_ms = '0; next_step_ms = '0;
    edge_gap = '0; edge_cnt = '0; target_mm = '0;
    req_pwm = '0; comp_pwm = '0; drive_pwm = '0;
    ramp_ph = edmr_pkg::PH_STOPPED; check_stop = 1'b0; bridge = edmr_pkg::MODE_BRAKE;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_motion(100, 0, 0);
    drain();  // hold off until the block is empty
    test_motion(100, 65, 0);
    load_setting(8'd255, 1'b1, 8'd0, 16'd65535, 8'd1, 8'd0, 8'd1, 8'd1);
    test_motion(100, 0, 65);
    test_speed_timeout();
    load_setting(8'd0, 1'b0, 8'd255, 16'd1, 8'd255, 8'd255, 8'd255, 8'd255);
    test_motion(100, 25, 25);
    load_setting(8'd5, 1'b1, 8'd1, 16'd30, 8'd3, 8'd20, 8'd200, 8'd40);
    test_motion(100, 65, 0);
    load_setting(8'd60, 1'b0, 8'd3, 16'd400, 8'd7, 8'd100, 8'd30, 8'd2);
    test_motion(100, 0, 0);
    load_setting(8'd2, 1'b0, 8'd2, 16'd200, 8'd20, 8'd50, 8'd8, 8'd11);
    test_motion(100, 25, 25);

    drain();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d beats, %0d status beats, %0d register settings,",
             n_items, n_results, n_cfg);
    $display("stop modes, ramps, braking, ringing and timeouts under idle and stall.");
    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/edmr_pkg.sv
rtl/core/edmr_in_if.sv
rtl/core/edmr_out_if.sv
rtl/core/edmr_div.sv
rtl/core/edmr_ctrl.sv
rtl/core/edmr_dp.sv
rtl/core/encoder_distance_motor_ramp.sv
tb/tb.sv
